/* hw/rtl/sot_pkg.sv */
// Shared types and codes for the station occupancy table.
// Used by the cell chain, the top level and the port checker.
package sot_pkg;

  localparam int STATIONS_DEF = 32;
  localparam logic [5:0] LAB_SIZE_RESET = 6'd32;

  typedef enum logic [1:0] {
    ACT_LOGIN     = 2'd0,
    ACT_LOGOUT    = 2'd1,
    ACT_FIND_USER = 2'd2,
    ACT_FIND_OPEN = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_OCCUPIED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NONE_OPEN = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  // Request token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic        valid;
    action_t     action;
    logic [5:0]  station;
    logic [15:0] user_id;
    logic [3:0]  lab_number;
    logic [15:0] minutes;
    logic [5:0]  limit;
    logic        done;
    status_t     status;
    logic [5:0]  res_station;
    logic [15:0] res_user;
    logic [3:0]  res_lab;
    logic [15:0] res_minutes;
  } probe_t;

endpackage

/* hw/rtl/sot_cell.sv */
// One station of the occupancy table: occupied mark and record.
// Passes the request token on to the next cell every cycle. Depends on sot_pkg.
module sot_cell import sot_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  probe_t probe_in,
  output probe_t probe_out
);

  localparam int NUM = IDX + 1;
  // Station numbers above 63 cannot be named by a request or fall below the limit.
  localparam logic REACH = (NUM < 64);
  localparam logic [5:0] NUM6 = 6'(NUM);

  logic        occupied;
  logic [15:0] user_q;
  logic [3:0]  lab_q;
  logic [15:0] minutes_q;

  probe_t probe_next;
  logic   login_hit;
  logic   user_hit;
  logic   open_hit;

  always_comb begin
    probe_next = probe_in;
    login_hit  = probe_in.valid && !probe_in.done && (probe_in.action == ACT_LOGIN) &&
                 REACH && (probe_in.station == NUM6);
    user_hit   = probe_in.valid && !probe_in.done && occupied &&
                 ((probe_in.action == ACT_LOGOUT) || (probe_in.action == ACT_FIND_USER)) &&
                 (user_q == probe_in.user_id);
    open_hit   = probe_in.valid && !probe_in.done && (probe_in.action == ACT_FIND_OPEN) &&
                 REACH && !occupied && (NUM6 <= probe_in.limit);

    if (login_hit) begin
      probe_next.done = 1'b1;
      if (occupied) begin
        probe_next.status = ST_OCCUPIED;
      end else begin
        probe_next.status      = ST_OK;
        probe_next.res_station = NUM6;
        probe_next.res_user    = probe_in.user_id;
        probe_next.res_lab     = probe_in.lab_number;
        probe_next.res_minutes = probe_in.minutes;
      end
    end
    if (user_hit) begin
      probe_next.done        = 1'b1;
      probe_next.status      = ST_OK;
      probe_next.res_station = NUM6;
      probe_next.res_user    = user_q;
      probe_next.res_lab     = lab_q;
      probe_next.res_minutes = minutes_q;
    end
    if (open_hit) begin
      probe_next.done        = 1'b1;
      probe_next.status      = ST_OK;
      probe_next.res_station = NUM6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (login_hit && !occupied) begin
      occupied <= 1'b1;
    end else if (user_hit && (probe_in.action == ACT_LOGOUT)) begin
      occupied <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (login_hit && !occupied) begin
      user_q    <= probe_in.user_id;
      lab_q     <= probe_in.lab_number;
      minutes_q <= probe_in.minutes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

/* hw/rtl/station_occupancy_table_top.sv */
// Station occupancy table, top level: request entry, cell chain, result register.
// Depends on sot_pkg and sot_cell.
//
// Each request walks a chain of STATIONS cells, one cell per cycle. The next request is taken
// once the previous one has left the chain and its result is gone or being taken. Login full
// and invalid-station checks and the occupancy count live at the chain's ends; logout and
// find-user return the lowest-numbered station held by the user, across all stations, and
// find-open the lowest-numbered open station up to the limit. The user must write lab_size
// over the cfg port only while no request is in flight; the block itself does not enforce it.
module station_occupancy_table_top import sot_pkg::*; #(
  parameter int STATIONS = STATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], station[7:2], user_id[23:8], lab_number[27:24], minutes[43:28]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], result_station[8:3], result_user[24:9], result_lab[28:25],
  // result_minutes[44:29]
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  localparam logic [5:0] LIM_CAP = 6'((STATIONS > 63) ? 63 : STATIONS);

  logic [5:0] lab_size;
  logic [5:0] occupied_count;
  logic       busy;
  logic [5:0] limit;
  logic       accept;

  probe_t chain [STATIONS+1];
  probe_t entry;
  probe_t entry_next;
  probe_t tail;

  status_t     out_status;
  logic [5:0]  out_station;
  logic [15:0] out_user;
  logic [3:0]  out_lab;
  logic [15:0] out_minutes;
  status_t     final_status;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign limit     = (lab_size > LIM_CAP) ? LIM_CAP : lab_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      lab_size <= LAB_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lab_size <= cfg_data;
    end
  end

  // Build the request token and settle the login full and invalid cases up front.
  always_comb begin
    entry_next             = '0;
    entry_next.valid       = 1'b1;
    entry_next.action      = action_t'(s_tdata[1:0]);
    entry_next.station     = s_tdata[7:2];
    entry_next.user_id     = s_tdata[23:8];
    entry_next.lab_number  = s_tdata[27:24];
    entry_next.minutes     = s_tdata[43:28];
    entry_next.limit       = limit;
    entry_next.status      = ST_OK;
    if (entry_next.action == ACT_LOGIN) begin
      if (occupied_count >= limit) begin
        entry_next.done   = 1'b1;
        entry_next.status = ST_FULL;
      end else if ((entry_next.station == 6'd0) || (entry_next.station > limit)) begin
        entry_next.done   = 1'b1;
        entry_next.status = ST_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (accept) begin
      entry <= entry_next;
    end else begin
      entry.valid <= 1'b0;
    end
  end

  assign chain[0] = entry;

  for (genvar k = 0; k < STATIONS; k++) begin : g_cell
    sot_cell #(
      .IDX(k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_in (chain[k]),
      .probe_out(chain[k+1])
    );
  end

  assign tail = chain[STATIONS];

  always_comb begin
    final_status = tail.status;
    if (!tail.done) begin
      final_status = (tail.action == ACT_FIND_OPEN) ? ST_NONE_OPEN : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (tail.valid) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_count <= 6'd0;
    end else if (tail.valid && tail.done && (tail.status == ST_OK)) begin
      if (tail.action == ACT_LOGIN) begin
        occupied_count <= occupied_count + 6'd1;
      end else if ((tail.action == ACT_LOGOUT) && (occupied_count != 6'd0)) begin
        occupied_count <= occupied_count - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tail.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      out_status  <= final_status;
      out_station <= tail.res_station;
      out_user    <= tail.res_user;
      out_lab     <= tail.res_lab;
      out_minutes <= tail.res_minutes;
    end
  end

  assign m_tdata = {3'd0, out_minutes, out_lab, out_user, out_station, out_status};

endmodule

/* hw/rtl/sot_checker.sv */
// Port-level checks for the station occupancy table, bound to the top level.
// Sees only the top level's ports. Depends on sot_pkg for the status codes.
module sot_checker import sot_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One request at a time: no second request right after one is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  // A result never shows up in the cycle after a request is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid)
    else $error("result appeared too early");

  // Error results carry no station or record.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[47:3] == 45'd0))
    else $error("error result with nonzero record");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ST_INVALID))
    else $error("status code out of range");

endmodule

bind station_occupancy_table_top sot_checker u_sot_checker (.*);
